// ----- hdl/dtdt_pkg.sv -----
// Shared types, constants and tables of the double to decimal text formatter.
`default_nettype none
package dtdt_pkg;

   localparam int BUFFER_CHARS_DEFAULT = 32;
   localparam int MAX_PRECISION = 14;
   localparam int PE_MAX = MAX_PRECISION - 1;
   localparam int P_W = 44;
   localparam int M_W = 53;
   localparam int S_W = 11;
   localparam int PROD_W = 97;
   localparam int T_W = 76;
   localparam int BCD_DIGITS = 23;
   localparam int BCD_W = BCD_DIGITS * 4;
   localparam int CNT_W = 7;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_NAN   = 2'd2;

   localparam logic [7:0] CSR_DEFAULT_PRECISION = 8'd0;
   localparam logic [7:0] CSR_PLAIN_LIMIT       = 8'd1;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_I     = 8'h69;

   typedef enum logic [1:0] {KIND_NUM, KIND_INF, KIND_RANGE, KIND_NAN} kind_type;

   typedef struct packed {
      logic [63:0] value_bits;
      logic [5:0]  precision;
      logic [5:0]  width;
      logic        flag_left;
      logic        flag_plus;
      logic        flag_space;
      logic        flag_zeropad;
      logic        flag_precision;
      logic [15:0] start_index;
      logic [15:0] max_length;
   } req_type;

   typedef struct packed {
      logic [7:0]  text_char;
      logic [16:0] position;
      logic        stored;
      logic        last;
      logic [1:0]  status;
      logic [16:0] end_index;
   } rsp_type;

   typedef struct packed {
      kind_type       kind;
      logic           has_sign;
      logic [7:0]     sign_char;
      logic [M_W-1:0] m;
      logic [S_W-1:0] s;
      logic [3:0]     pe;
      logic [CNT_W-1:0] z;
      logic [5:0]     width;
      logic           left;
      logic           zero;
      logic [15:0]    start;
      logic [15:0]    maxlen;
   } job_type;

   function automatic logic [P_W-1:0] pow10(input logic [3:0] e);
      logic [P_W-1:0] r;
      case (e)
         4'd0:    r = 44'd1;
         4'd1:    r = 44'd10;
         4'd2:    r = 44'd100;
         4'd3:    r = 44'd1000;
         4'd4:    r = 44'd10000;
         4'd5:    r = 44'd100000;
         4'd6:    r = 44'd1000000;
         4'd7:    r = 44'd10000000;
         4'd8:    r = 44'd100000000;
         4'd9:    r = 44'd1000000000;
         4'd10:   r = 44'd10000000000;
         4'd11:   r = 44'd100000000000;
         4'd12:   r = 44'd1000000000000;
         default: r = 44'd10000000000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/dtdt_front.sv -----
// Front end: accepts a request, decodes the double and classifies it into a job.
`default_nettype none
module dtdt_front #(
   parameter int BUFFER_CHARS = dtdt_pkg::BUFFER_CHARS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dtdt_pkg::req_type req_data,
   input  wire logic [3:0]        default_precision,
   input  wire logic [31:0]       plain_limit,
   output logic                   push,
   output dtdt_pkg::job_type      job,
   input  wire logic              q_full
);

   logic              hold_valid_ff, hold_valid_in;
   dtdt_pkg::req_type hold_ff;

   logic [10:0]                ex, exu;
   logic                       sgn;
   logic [dtdt_pkg::M_W-1:0]   m, ip;
   logic [dtdt_pkg::S_W-1:0]   s;
   logic                       fracnz, over, neg;
   logic [5:0]                 prec, zt;

   always_comb begin
      sgn = hold_ff.value_bits[63];
      ex  = hold_ff.value_bits[62:52];
      m   = {(ex != 11'd0), hold_ff.value_bits[51:0]};
      exu = (ex == 11'd0) ? 11'd1 : ex;
      s   = 11'd1075 - exu;
      if (s >= 11'(dtdt_pkg::M_W)) begin
         ip     = '0;
         fracnz = (m != '0);
      end else begin
         ip     = m >> s[5:0];
         fracnz = (m & ((dtdt_pkg::M_W'(1) << s[5:0]) - dtdt_pkg::M_W'(1))) != '0;
      end
      over = (ip > {21'd0, plain_limit}) || ((ip == {21'd0, plain_limit}) && fracnz);
      neg  = sgn && (m != '0);
      prec = hold_ff.flag_precision ? hold_ff.precision : {2'b00, default_precision};

      job        = '0;
      job.m      = m;
      job.s      = s;
      job.width  = hold_ff.width;
      job.left   = hold_ff.flag_left;
      job.zero   = hold_ff.flag_zeropad;
      job.start  = hold_ff.start_index;
      job.maxlen = hold_ff.max_length;
      zt = prec - 6'(dtdt_pkg::PE_MAX);
      if (prec >= 6'(dtdt_pkg::MAX_PRECISION)) begin
         job.z  = (7'(zt) > 7'(BUFFER_CHARS)) ? 7'(BUFFER_CHARS) : 7'(zt);
         job.pe = 4'(dtdt_pkg::PE_MAX);
      end else begin
         job.z  = '0;
         job.pe = prec[3:0];
      end
      if (ex == 11'h7FF) begin
         job.kind      = (hold_ff.value_bits[51:0] != '0) ? dtdt_pkg::KIND_NAN
                                                          : dtdt_pkg::KIND_INF;
         job.has_sign  = sgn || hold_ff.flag_plus;
         job.sign_char = sgn ? dtdt_pkg::CH_MINUS : dtdt_pkg::CH_PLUS;
      end else begin
         job.kind      = (exu >= 11'd1075 || over) ? dtdt_pkg::KIND_RANGE
                                                   : dtdt_pkg::KIND_NUM;
         job.has_sign  = neg || hold_ff.flag_plus || hold_ff.flag_space;
         job.sign_char = neg ? dtdt_pkg::CH_MINUS
                       : (hold_ff.flag_plus ? dtdt_pkg::CH_PLUS : dtdt_pkg::CH_SPACE);
      end
   end

   assign push      = hold_valid_ff && !q_full;
   assign req_ready = !hold_valid_ff || !q_full;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_ready) hold_valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (req_valid && req_ready) hold_ff <= req_data;
   end

endmodule
`default_nettype wire

// ----- hdl/dtdt_queue.sv -----
// Two-entry job queue between the front end and the back end.
`default_nettype none
module dtdt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dtdt_pkg::job_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output dtdt_pkg::job_type      pop_data,
   output logic                   empty
);

   dtdt_pkg::job_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ----- hdl/dtdt_back.sv -----
// Back end: exact scaling, binary to BCD conversion, rounding and character output.
`default_nettype none
module dtdt_back #(
   parameter int BUFFER_CHARS = dtdt_pkg::BUFFER_CHARS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire dtdt_pkg::job_type q_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dtdt_pkg::rsp_type      rsp_data
);

   localparam int PW = dtdt_pkg::PROD_W;
   localparam int BW = dtdt_pkg::BCD_W;
   localparam int CW = dtdt_pkg::CNT_W;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_SHIFT, S_CONV, S_ROUND, S_DIGITS, S_PREP, S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   dtdt_pkg::job_type job_ff, job_in;
   logic [dtdt_pkg::P_W-1:0] p_ff, p_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic [48:0]       prod_ff, prod_in;
   logic [5:0]        pshift_ff, pshift_in;
   logic [2:0]        step_ff, step_in;
   logic [dtdt_pkg::T_W-1:0] bin_ff, bin_in;
   logic [BW-1:0]     bcd_ff, bcd_in;
   logic              half_ff, half_in, below_ff, below_in;
   logic [5:0]        conv_ff, conv_in;
   logic [4:0]        nip_ff, nip_in;
   logic [CW-1:0]     fe_ff, fe_in, ipstart_ff, ipstart_in, ipend_ff, ipend_in;
   logic [CW-1:0]     padend_ff, padend_in, len_ff, len_in, lead_ff, lead_in;
   logic [CW-1:0]     total_ff, total_in, k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dtdt_pkg::rsp_type rsp_ff, rsp_in;

   function automatic logic [BW-1:0] dabble_step(input logic [BW-1:0] v, input logic b);
      logic [BW-1:0] t;
      t = v;
      for (int i = 0; i < dtdt_pkg::BCD_DIGITS; i++) begin
         if (t[i*4 +: 4] >= 4'd5) t[i*4 +: 4] = t[i*4 +: 4] + 4'd3;
      end
      return {t[BW-2:0], b};
   endfunction

   function automatic logic [BW-1:0] bcd_increment(input logic [BW-1:0] v);
      logic [BW-1:0]                   r;
      logic [dtdt_pkg::BCD_DIGITS-1:0] nine, lowmask;
      for (int i = 0; i < dtdt_pkg::BCD_DIGITS; i++) nine[i] = (v[i*4 +: 4] == 4'd9);
      for (int i = 0; i < dtdt_pkg::BCD_DIGITS; i++) begin
         lowmask = (dtdt_pkg::BCD_DIGITS'(1) << i) - dtdt_pkg::BCD_DIGITS'(1);
         if ((nine & lowmask) == lowmask)
            r[i*4 +: 4] = nine[i] ? 4'd0 : v[i*4 +: 4] + 4'd1;
         else
            r[i*4 +: 4] = v[i*4 +: 4];
      end
      return r;
   endfunction

   logic [3:0]    dig [dtdt_pkg::BCD_DIGITS];
   logic [26:0]   mul_a;
   logic [21:0]   mul_b;
   logic [6:0]    s7;
   logic [PW-1:0] sh_t, sh_h, bmask;
   logic          odd, nz, rnd;
   logic [4:0]    ndig;
   logic [CW-1:0] wz, full_len, w7, b, fi_idx, ip_idx;
   logic [7:0]    ch;
   logic [16:0]   pos;
   logic          out_free, is_last;

   always_comb begin
      for (int i = 0; i < dtdt_pkg::BCD_DIGITS; i++) dig[i] = bcd_ff[i*4 +: 4];
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == S_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;   job_in = job_ff;     p_in = p_ff;
      acc_in = acc_ff;       prod_in = prod_ff;   pshift_in = pshift_ff;
      step_in = step_ff;     bin_in = bin_ff;     bcd_in = bcd_ff;
      half_in = half_ff;     below_in = below_ff; conv_in = conv_ff;
      nip_in = nip_ff;       fe_in = fe_ff;       ipstart_in = ipstart_ff;
      ipend_in = ipend_ff;   padend_in = padend_ff; len_in = len_ff;
      lead_in = lead_ff;     total_in = total_ff; k_in = k_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      mul_a = step_ff[1] ? {1'b0, job_ff.m[52:27]} : job_ff.m[26:0];
      mul_b = step_ff[0] ? p_ff[43:22] : p_ff[21:0];
      s7    = (job_ff.s >= 11'd98) ? 7'd98 : job_ff.s[6:0];
      sh_t  = acc_ff >> s7;
      sh_h  = acc_ff >> (s7 - 7'd1);
      bmask = (PW'(1) << (s7 - 7'd1)) - PW'(1);

      odd = bcd_ff[0];
      nz  = 1'b0;
      for (int i = 0; i < dtdt_pkg::PE_MAX; i++) begin
         if (i < int'(job_ff.pe) && dig[i] != 4'd0) nz = 1'b1;
      end
      rnd = half_ff && (below_ff || odd || (job_ff.pe != 4'd0 && !nz));

      ndig = 5'd0;
      for (int i = 0; i < dtdt_pkg::BCD_DIGITS; i++) begin
         if (dig[i] != 4'd0) ndig = 5'(i + 1);
      end

      w7       = CW'(job_ff.width);
      wz       = w7 - CW'(job_ff.width != 6'd0 && job_ff.has_sign);
      full_len = padend_ff + CW'(job_ff.has_sign);

      // b walks the built text from its high end down to zero
      b      = lead_ff + len_ff - CW'(1) - k_ff;
      fi_idx = b - job_ff.z;
      ip_idx = CW'(job_ff.pe) + (b - ipstart_ff);
      if (k_ff < lead_ff || k_ff >= lead_ff + len_ff) begin
         ch = dtdt_pkg::CH_SPACE;
      end else if (job_ff.kind == dtdt_pkg::KIND_INF) begin
         case (b)
            7'd0:    ch = dtdt_pkg::CH_F;
            7'd1:    ch = dtdt_pkg::CH_N;
            7'd2:    ch = dtdt_pkg::CH_I;
            default: ch = job_ff.sign_char;
         endcase
      end else if (b < job_ff.z) begin
         ch = dtdt_pkg::CH_ZERO;
      end else if (b < fe_ff) begin
         ch = {4'h3, dig[fi_idx[4:0]]};
      end else if (b == fe_ff && job_ff.pe != 4'd0) begin
         ch = dtdt_pkg::CH_DOT;
      end else if (b < ipend_ff) begin
         ch = {4'h3, dig[ip_idx[4:0]]};
      end else if (b < padend_ff) begin
         ch = dtdt_pkg::CH_ZERO;
      end else begin
         ch = job_ff.sign_char;
      end
      pos     = {1'b0, job_ff.start} + 17'(k_ff);
      is_last = (k_ff == total_ff - CW'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               job_in  = q_data;
               p_in    = dtdt_pkg::pow10(q_data.pe);
               acc_in  = '0;
               step_in = '0;
               k_in    = '0;
               if (q_data.kind == dtdt_pkg::KIND_NUM) state_in = S_MUL;
               else                                   state_in = S_PREP;
            end
         end
         S_MUL: begin
            if (step_ff != 3'd4) begin
               prod_in   = mul_a * mul_b;
               pshift_in = (step_ff[0] ? 6'd22 : 6'd0) + (step_ff[1] ? 6'd27 : 6'd0);
            end
            if (step_ff != 3'd0) acc_in = acc_ff + (PW'(prod_ff) << pshift_ff);
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) state_in = S_SHIFT;
         end
         S_SHIFT: begin
            bin_in   = sh_t[dtdt_pkg::T_W-1:0];
            half_in  = sh_h[0];
            below_in = (acc_ff & bmask) != '0;
            bcd_in   = '0;
            conv_in  = '0;
            state_in = S_CONV;
         end
         S_CONV: begin
            bcd_in  = dabble_step(dabble_step(bcd_ff, bin_ff[dtdt_pkg::T_W-1]),
                                  bin_ff[dtdt_pkg::T_W-2]);
            bin_in  = {bin_ff[dtdt_pkg::T_W-3:0], 2'b00};
            conv_in = conv_ff + 6'd1;
            if (conv_ff == 6'(dtdt_pkg::T_W / 2 - 1)) state_in = S_ROUND;
         end
         S_ROUND: begin
            if (rnd) bcd_in = bcd_increment(bcd_ff);
            state_in = S_DIGITS;
         end
         S_DIGITS: begin
            nip_in     = (ndig > {1'b0, job_ff.pe}) ? ndig - {1'b0, job_ff.pe} : 5'd1;
            fe_in      = job_ff.z + CW'(job_ff.pe);
            ipstart_in = job_ff.z + CW'(job_ff.pe) + CW'(job_ff.pe != 4'd0);
            state_in   = S_PREP;
         end
         S_PREP: begin
            ipend_in  = ipstart_ff + CW'(nip_ff);
            padend_in = (!job_ff.left && job_ff.zero && wz > ipstart_ff + CW'(nip_ff))
                      ? wz : ipstart_ff + CW'(nip_ff);
            state_in  = S_EMIT;
            if (job_ff.kind == dtdt_pkg::KIND_NUM) begin
               // padend is still the old value here; finish the length next cycle
               state_in = S_PREP;
               if (padend_in == padend_ff && ipend_ff == ipend_in) begin
                  len_in   = (full_len > CW'(BUFFER_CHARS)) ? CW'(BUFFER_CHARS) : full_len;
                  state_in = S_EMIT;
               end
            end else begin
               len_in = CW'(3) + CW'(job_ff.has_sign);
            end
            if (state_in == S_EMIT) begin
               if (job_ff.kind == dtdt_pkg::KIND_RANGE || job_ff.kind == dtdt_pkg::KIND_NAN) begin
                  lead_in  = '0;
                  total_in = CW'(1);
               end else begin
                  // zero padding without left justify adds no spaces
                  lead_in  = (!job_ff.left && !job_ff.zero && w7 > len_in) ? w7 - len_in : '0;
                  total_in = (w7 > len_in && (job_ff.left || !job_ff.zero)) ? w7 : len_in;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (job_ff.kind == dtdt_pkg::KIND_RANGE || job_ff.kind == dtdt_pkg::KIND_NAN) begin
                  rsp_in.text_char = 8'd0;
                  rsp_in.position  = {1'b0, job_ff.start};
                  rsp_in.stored    = 1'b0;
                  rsp_in.last      = 1'b1;
                  rsp_in.status    = (job_ff.kind == dtdt_pkg::KIND_NAN)
                                   ? dtdt_pkg::STATUS_NAN : dtdt_pkg::STATUS_RANGE;
                  rsp_in.end_index = {1'b0, job_ff.start} + 17'd1;
               end else begin
                  rsp_in.text_char = ch;
                  rsp_in.position  = pos;
                  rsp_in.stored    = pos < {1'b0, job_ff.maxlen};
                  rsp_in.last      = is_last;
                  rsp_in.status    = dtdt_pkg::STATUS_OK;
                  rsp_in.end_index = is_last ? {1'b0, job_ff.start} + 17'(total_ff) : 17'd0;
               end
               k_in = k_ff + CW'(1);
               if (is_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff     <= job_in;     p_ff      <= p_in;      acc_ff     <= acc_in;
      prod_ff    <= prod_in;    pshift_ff <= pshift_in; step_ff    <= step_in;
      bin_ff     <= bin_in;     bcd_ff    <= bcd_in;    half_ff    <= half_in;
      below_ff   <= below_in;   conv_ff   <= conv_in;   nip_ff     <= nip_in;
      fe_ff      <= fe_in;      ipstart_ff <= ipstart_in; ipend_ff <= ipend_in;
      padend_ff  <= padend_in;  len_ff    <= len_in;    lead_ff    <= lead_in;
      total_ff   <= total_in;   k_ff      <= k_in;      rsp_ff     <= rsp_in;
   end

endmodule
`default_nettype wire

// ----- hdl/double_to_decimal_text.sv -----
// Top level of the double to decimal text formatter: registers, front, queue, back.
`default_nettype none
// Formats one IEEE double per request as printf fixed-point text and returns it one
// character per response, in reading order, with its buffer position and a stored
// flag; NaN and values above plain_limit return a single status-only response.
// The front end holds one request while two more wait in the job queue, and takes a
// new request unless it holds one and the queue is full. For each finite value the
// back end runs a split multiply, a shift, two-bit-per-cycle binary to BCD
// conversion, rounding and length setup, then emits max(width, text length)
// characters as rsp_ready allows; infinities and status results skip the arithmetic.
module double_to_decimal_text #(
   parameter int BUFFER_CHARS = dtdt_pkg::BUFFER_CHARS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dtdt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dtdt_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_index,
   input  wire logic [31:0]       csr_data
);

   logic [3:0]        default_precision_ff, default_precision_in;
   logic [31:0]       plain_limit_ff, plain_limit_in;
   logic              push, q_full, q_empty, pop;
   dtdt_pkg::job_type push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      default_precision_in = default_precision_ff;
      plain_limit_in       = plain_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dtdt_pkg::CSR_DEFAULT_PRECISION: default_precision_in = csr_data[3:0];
            dtdt_pkg::CSR_PLAIN_LIMIT:       plain_limit_in       = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_precision_ff <= 4'd6;
         plain_limit_ff       <= 32'd1000000000;
      end else begin
         default_precision_ff <= default_precision_in;
         plain_limit_ff       <= plain_limit_in;
      end
   end

   dtdt_front #(.BUFFER_CHARS(BUFFER_CHARS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .default_precision(default_precision_ff), .plain_limit(plain_limit_ff),
      .push(push), .job(push_data), .q_full(q_full)
   );

   dtdt_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(q_full),
      .pop(pop), .pop_data(pop_data), .empty(q_empty)
   );

   dtdt_back #(.BUFFER_CHARS(BUFFER_CHARS)) u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_data(pop_data), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // status-only transactions are single and never stored
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != dtdt_pkg::STATUS_OK |-> rsp_data.last)
      else $error("status response without last");

   a_status_nostore: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != dtdt_pkg::STATUS_OK |-> !rsp_data.stored)
      else $error("status response marked stored");

   a_end_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.end_index == 17'd0)
      else $error("end index on non-final character");

   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last ##1 rsp_valid
      |-> rsp_data.position == $past(rsp_data.position) + 17'd1)
      else $error("character positions not consecutive");

endmodule
`default_nettype wire
